>>> sv/hmts_pkg.sv
`timescale 1ns / 1ps

package hmts_pkg;

  localparam int CELLS_PER_SIDE = 128;
  localparam int CELL_BITS = $clog2(CELLS_PER_SIDE);
  localparam int CORNER_SIDE = CELLS_PER_SIDE + 1;
  localparam int CORNER_DEPTH = CORNER_SIDE * CORNER_SIDE;
  localparam int CENTRE_DEPTH = CELLS_PER_SIDE * CELLS_PER_SIDE;
  localparam int CENTRE_ADDR_BITS = 2 * CELL_BITS;
  localparam int BANK_SIDE = CELLS_PER_SIDE / 2 + 1;
  localparam int BANK_DEPTH = BANK_SIDE * BANK_SIDE;
  localparam int BANK_ADDR_BITS = $clog2(BANK_DEPTH);

  localparam logic [1:0] OP_CORNER = 2'd0;
  localparam logic [1:0] OP_CENTRE = 2'd1;
  localparam logic [1:0] OP_QUERY = 2'd2;
  localparam logic [1:0] OP_UNUSED = 2'd3;

  localparam logic [2:0] CFG_MODE = 3'd0;
  localparam logic [2:0] CFG_SCALE = 3'd1;
  localparam logic [2:0] CFG_OFFSET = 3'd2;
  localparam logic [2:0] CFG_BASE = 3'd3;
  localparam logic [2:0] CFG_STEP = 3'd4;

  typedef logic [CELL_BITS:0] corner_coord_t;
  typedef logic [BANK_ADDR_BITS-1:0] bank_addr_t;

  function automatic bank_addr_t bank_addr(input corner_coord_t x, input corner_coord_t y);
    bank_addr = BANK_ADDR_BITS'(x[CELL_BITS:1]) * BANK_ADDR_BITS'(BANK_SIDE)
              + BANK_ADDR_BITS'(y[CELL_BITS:1]);
  endfunction

endpackage

>>> sv/hmts_ram.sv
`timescale 1ns / 1ps

module hmts_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> sv/heightmap_triangle_sampler.sv
`timescale 1ns / 1ps
// Heightmap sampler: every cycle while busy is low it takes one transaction (a corner write, a
// centre write or a height query); a query passes through the eight-stage pipeline around the
// height stores and the multiplier stages and returns its height with done high for one cycle.
// The receiver cannot stall, so results must be taken as they appear. The corner heights live
// in four banks split by the parity of the corner row and column so that all four corners of a
// cell are read in the same cycle. Stores come up undefined after reset and must be written
// before they are queried.
module heightmap_triangle_sampler import hmts_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         operation,
  input  logic signed [31:0] pos_x,
  input  logic signed [31:0] pos_y,
  input  logic [14:0]        table_index,
  input  logic [15:0]        height_word,
  output logic               done,
  output logic signed [31:0] height,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data
);

  logic               height_mode;
  logic [23:0]        cell_scale;
  logic [27:0]        cell_offset;
  logic signed [31:0] base_height;
  logic [31:0]        height_step;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      height_mode <= 1'b0;
      cell_scale <= '0;
      cell_offset <= '0;
      base_height <= '0;
      height_step <= '0;
      busy <= 1'b1;
    end else begin
      busy <= 1'b0;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_MODE: height_mode <= cfg_data[0];
          CFG_SCALE: cell_scale <= cfg_data[23:0];
          CFG_OFFSET: cell_offset <= cfg_data[27:0];
          CFG_BASE: base_height <= cfg_data;
          CFG_STEP: height_step <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  // Stage 1: position times scale.
  logic               s1_valid;
  logic [1:0]         s1_op;
  logic signed [56:0] s1_prod_x, s1_prod_y;
  logic [14:0]        s1_index;
  logic [15:0]        s1_word;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= start && !busy;
    end
    s1_op <= operation;
    s1_prod_x <= 57'(pos_x) * $signed({33'd0, cell_scale});
    s1_prod_y <= 57'(pos_y) * $signed({33'd0, cell_scale});
    s1_index <= table_index;
    s1_word <= height_word;
  end

  // Stage 2: cell coordinates and fractions, write index split into row and column.
  logic signed [57:0] coord_x, coord_y, offset_ext;
  logic [15:0]        est0, est1, est2;
  logic signed [16:0] rem0, rem1, rem2;

  assign offset_ext = $signed({14'd0, cell_offset, 16'd0});
  assign coord_x = offset_ext - 58'(s1_prod_x);
  assign coord_y = offset_ext - 58'(s1_prod_y);

  always_comb begin
    est0 = 16'(s1_index >> CELL_BITS);
    rem0 = $signed({2'b00, s1_index}) - $signed(17'(est0) * 17'(CORNER_SIDE));
    est1 = est0;
    rem1 = rem0;
    if (rem0 < 0) begin
      est1 = est0 - 16'd1;
      rem1 = rem0 + 17'(CORNER_SIDE);
    end
    est2 = est1;
    rem2 = rem1;
    if (rem1 < 0) begin
      est2 = est1 - 16'd1;
      rem2 = rem1 + 17'(CORNER_SIDE);
    end
  end

  logic                 s2_valid;
  logic [1:0]           s2_op;
  logic                 s2_flat;
  logic [CELL_BITS-1:0] s2_ix, s2_iy;
  logic [15:0]          s2_fx, s2_fy;
  corner_coord_t        s2_wx, s2_wy;
  logic                 s2_corner_ok, s2_centre_ok;
  logic [CENTRE_ADDR_BITS-1:0] s2_centre_addr;
  logic [15:0]          s2_word;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else begin
      s2_valid <= s1_valid;
    end
    s2_op <= s1_op;
    s2_flat <= !height_mode;
    s2_ix <= coord_x[32 +: CELL_BITS];
    s2_iy <= coord_y[32 +: CELL_BITS];
    s2_fx <= coord_x[31:16];
    s2_fy <= coord_y[31:16];
    s2_wx <= est2[CELL_BITS:0];
    s2_wy <= rem2[CELL_BITS:0];
    s2_corner_ok <= 32'(s1_index) < 32'(CORNER_DEPTH);
    s2_centre_ok <= 32'(s1_index) < 32'(CENTRE_DEPTH);
    s2_centre_addr <= s1_index[CENTRE_ADDR_BITS-1:0];
    s2_word <= s1_word;
  end

  // Memory access: writes and reads happen at the same stage, so program order holds.
  logic [15:0] corner_rd [4];
  logic [15:0] centre_rd;

  for (genvar k = 0; k < 4; k++) begin : g_bank
    localparam logic PX = 1'((k >> 1) & 1);
    localparam logic PY = 1'(k & 1);
    corner_coord_t qx, qy;
    logic          bank_we;

    assign qx = {1'b0, s2_ix} + corner_coord_t'(s2_ix[0] ^ PX);
    assign qy = {1'b0, s2_iy} + corner_coord_t'(s2_iy[0] ^ PY);
    assign bank_we = s2_valid && (s2_op == OP_CORNER) && s2_corner_ok
                   && (s2_wx[0] == PX) && (s2_wy[0] == PY);

    hmts_ram #(.WIDTH(16), .DEPTH(BANK_DEPTH)) u_corner (
      .clk  (clk),
      .we   (bank_we),
      .waddr(bank_addr(s2_wx, s2_wy)),
      .wdata(s2_word),
      .raddr(bank_addr(qx, qy)),
      .rdata(corner_rd[k])
    );
  end

  hmts_ram #(.WIDTH(16), .DEPTH(CENTRE_DEPTH)) u_centre (
    .clk  (clk),
    .we   (s2_valid && (s2_op == OP_CENTRE) && s2_centre_ok),
    .waddr(s2_centre_addr),
    .wdata(s2_word),
    .raddr({s2_ix, s2_iy}),
    .rdata(centre_rd)
  );

  // Stage 3: heights available, pick the triangle.
  logic        s3_valid, s3_flat, s3_px, s3_py;
  logic [15:0] s3_fx, s3_fy;

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
    end else begin
      s3_valid <= s2_valid && (s2_op == OP_QUERY);
    end
    s3_flat <= s2_flat;
    s3_px <= s2_ix[0];
    s3_py <= s2_iy[0];
    s3_fx <= s2_fx;
    s3_fy <= s2_fy;
  end

  logic signed [19:0] h1, h2, h3, h4, h5, ca, cb, cc;
  logic [16:0]        fsum;

  always_comb begin
    h1 = 20'(corner_rd[{s3_px, s3_py}]);
    h2 = 20'(corner_rd[{!s3_px, s3_py}]);
    h3 = 20'(corner_rd[{s3_px, !s3_py}]);
    h4 = 20'(corner_rd[{!s3_px, !s3_py}]);
    h5 = 20'({centre_rd, 1'b0});
    fsum = 17'(s3_fx) + 17'(s3_fy);
    if (!fsum[16]) begin
      if (s3_fx > s3_fy) begin
        ca = h2 - h1;
        cb = h5 - h1 - h2;
      end else begin
        ca = h5 - h1 - h3;
        cb = h3 - h1;
      end
      cc = h1;
    end else begin
      if (s3_fx > s3_fy) begin
        ca = h2 + h4 - h5;
        cb = h4 - h2;
      end else begin
        ca = h4 - h3;
        cb = h3 + h4 - h5;
      end
      cc = h5 - h4;
    end
  end

  logic               s4_valid, s4_flat;
  logic signed [19:0] s4_a, s4_b, s4_c;
  logic [15:0]        s4_fx, s4_fy;

  always_ff @(posedge clk) begin
    if (rst) begin
      s4_valid <= 1'b0;
    end else begin
      s4_valid <= s3_valid;
    end
    s4_flat <= s3_flat;
    s4_a <= ca;
    s4_b <= cb;
    s4_c <= cc;
    s4_fx <= s3_fx;
    s4_fy <= s3_fy;
  end

  // Stage 5: plane evaluation in quantization steps with 16 fraction bits.
  logic               s5_valid, s5_flat;
  logic signed [37:0] s5_v;

  always_ff @(posedge clk) begin
    if (rst) begin
      s5_valid <= 1'b0;
    end else begin
      s5_valid <= s4_valid;
    end
    s5_flat <= s4_flat;
    s5_v <= 38'(s4_a) * 38'($signed({1'b0, s4_fx}))
          + 38'(s4_b) * 38'($signed({1'b0, s4_fy}))
          + 38'($signed({s4_c, 16'd0}));
  end

  // Stage 6: step multiply in two halves.
  logic               s6_valid, s6_flat;
  logic signed [54:0] s6_hi, s6_lo;

  always_ff @(posedge clk) begin
    if (rst) begin
      s6_valid <= 1'b0;
    end else begin
      s6_valid <= s5_valid;
    end
    s6_flat <= s5_flat;
    s6_hi <= 55'(s5_v) * $signed({39'd0, height_step[31:16]});
    s6_lo <= 55'(s5_v) * $signed({39'd0, height_step[15:0]});
  end

  logic               s7_valid, s7_flat;
  logic signed [55:0] s7_t;

  always_ff @(posedge clk) begin
    if (rst) begin
      s7_valid <= 1'b0;
    end else begin
      s7_valid <= s6_valid;
    end
    s7_flat <= s6_flat;
    s7_t <= 56'(s6_hi) + 56'(s6_lo >>> 16);
  end

  // Stage 8: add base height and saturate.
  logic signed [40:0] sum;
  logic signed [31:0] sat;

  always_comb begin
    sum = 41'(base_height) + 41'(s7_t >>> 16);
    if (sum > 41'sd2147483647) begin
      sat = 32'sh7fffffff;
    end else if (sum < -41'sd2147483648) begin
      sat = 32'sh80000000;
    end else begin
      sat = sum[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= s7_valid;
    end
    height <= s7_flat ? base_height : sat;
  end

endmodule

>>> sv/hmts_check.sv
`timescale 1ns / 1ps

module hmts_check import hmts_pkg::*; (
  input logic       clk,
  input logic       rst,
  input logic       start,
  input logic       busy,
  input logic [1:0] operation,
  input logic       done
);

  a_done_follows_query: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy && !rst && (operation == OP_QUERY), 8))
    else $error("result without a query transaction eight cycles earlier");

  a_no_done_while_busy: assert property (@(posedge clk) disable iff (rst)
    busy |-> !done)
    else $error("result while the block is busy");

  a_quiet_after_reset: assert property (@(posedge clk) disable iff (rst)
    $past(rst) |-> !done)
    else $error("result right after reset");

endmodule

bind heightmap_triangle_sampler hmts_check u_hmts_check (
  .clk      (clk),
  .rst      (rst),
  .start    (start),
  .busy     (busy),
  .operation(operation),
  .done     (done)
);
